/* hdl/sli_pkg.sv */
package sli_pkg;

  localparam int DATA_W = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_LISTED    = 3'd5;

  // controller to datapath commands
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic show_empty;
    logic list_step;
    logic list_last;
  } sli_ctl_t;

endpackage

/* hdl/sli_datapath.sv */
module sli_datapath import sli_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sli_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic [CNT_W-1:0]         count,
  output logic                     result_strobe,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     last
);

  logic signed [DATA_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eqm;
  logic [CAPACITY-1:0] hit;
  logic                full;
  logic                found;

  assign full  = (count == CNT_W'(CAPACITY));
  assign found = hit[CAPACITY-1];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                     valid;
      logic signed [DATA_W-1:0] ins_val;
      logic signed [DATA_W-1:0] rem_val;
      logic signed [DATA_W-1:0] rot_val;

      assign valid   = (CNT_W'(gi) < count);
      assign lt[gi]  = valid && (entries[gi] < operand_value);
      assign eqm[gi] = valid && (entries[gi] == operand_value);
      // first match at or below this slot
      assign hit[gi] = |eqm[gi:0];

      // insert: keep smaller values, drop operand at boundary, shift rest up
      if (gi == 0) begin : g_ins0
        assign ins_val = lt[0] ? entries[0] : operand_value;
      end else begin : g_insn
        assign ins_val = lt[gi] ? entries[gi] :
                         (lt[gi-1] ? operand_value : entries[gi-1]);
      end

      // remove: slots at and above the match pull from above
      // display: rotate the occupied slots down, head wraps to the top
      if (gi == CAPACITY - 1) begin : g_top
        assign rem_val = entries[gi];
        assign rot_val = (CNT_W'(gi) == count - CNT_W'(1)) ? entries[0] : entries[gi];
      end else begin : g_mid
        assign rem_val = hit[gi] ? entries[gi+1] : entries[gi];
        assign rot_val = (CNT_W'(gi + 1) < count) ? entries[gi+1] :
                         ((CNT_W'(gi) == count - CNT_W'(1)) ? entries[0] : entries[gi]);
      end

      always_ff @(posedge clk) begin
        if (ctl.do_insert && !full) begin
          entries[gi] <= ins_val;
        end else if (ctl.do_remove && found) begin
          entries[gi] <= rem_val;
        end else if (ctl.list_step) begin
          entries[gi] <= rot_val;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctl.do_insert || ctl.do_remove || ctl.show_empty || ctl.list_step;
      if (ctl.do_insert && !full) begin
        count <= count + CNT_W'(1);
      end else if (ctl.do_remove && found) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      status       <= full ? ST_FULL : ST_INSERTED;
      result_value <= operand_value;
      last         <= 1'b1;
    end else if (ctl.do_remove) begin
      if (count == '0) begin
        status <= ST_EMPTY;
      end else if (!found) begin
        status <= ST_NOT_FOUND;
      end else begin
        status <= ST_DELETED;
      end
      result_value <= operand_value;
      last         <= 1'b1;
    end else if (ctl.show_empty) begin
      status       <= ST_EMPTY;
      result_value <= '0;
      last         <= 1'b1;
    end else if (ctl.list_step) begin
      status       <= ST_LISTED;
      result_value <= entries[0];
      last         <= ctl.list_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_list_result: assert property (@(posedge clk) disable iff (rst)
    ctl.list_step |=> result_strobe && status == ST_LISTED)
    else $error("list step produced no listed entry");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.do_insert && !full |=> count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not grow the store");

endmodule

/* hdl/sli_ctrl.sv */
module sli_ctrl import sli_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  logic [CNT_W-1:0] count,
  output logic             busy,
  output sli_ctl_t         ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LIST = 1'b1;

  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             accept;
  logic             at_end;

  assign busy   = (state == S_LIST);
  assign accept = start && !busy;
  assign at_end = ((CNT_W'(idx) + CNT_W'(1)) == count);

  always_comb begin
    ctl        = '0;
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_INSERT: ctl.do_insert = 1'b1;
            CMD_REMOVE: ctl.do_remove = 1'b1;
            CMD_DISPLAY: begin
              if (count == '0) begin
                ctl.show_empty = 1'b1;
              end else begin
                state_next = S_LIST;
                idx_next   = '0;
              end
            end
            default: ;  // drop unused code
          endcase
        end
      end
      S_LIST: begin
        ctl.list_step = 1'b1;
        ctl.list_last = at_end;
        if (at_end) begin
          state_next = S_IDLE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("listing an empty store");

  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    ctl.list_step && ctl.list_last |=> !busy)
    else $error("listing did not stop after last entry");

  a_list_starts: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_DISPLAY && count != '0 |=> busy)
    else $error("display of nonempty store did not start listing");

endmodule

/* hdl/sorted_list_insert_remove_unit.sv */
// Sorted list unit: keeps up to CAPACITY signed 32-bit values in ascending order.
//
// Input: an item (command, operand_value) is taken at a rising edge where start is
// high and busy is low. Commands: insert, remove, display; the unused code is
// dropped with no result.
// Output: each result shows on status/result_value/last for one cycle with
// result_strobe high. last marks the final result of an item.
// Insert and remove update the store at the accept edge, and their single result
// appears in the next cycle; busy stays low, so a new item may follow each cycle.
// A display of n entries keeps busy high while the list state emits them, rotating
// the register row one slot per cycle and emitting the head, so results come one
// per cycle from the list state. The display rate is set by that single read port
// at slot 0. An empty display gives one empty result in the next cycle.
// Reset: the entry count clears; no result is pending. Entry contents are not reset.
// The receiver cannot stall: every result must be taken in its strobe cycle.
module sorted_list_insert_remove_unit import sli_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic                     result_strobe,
  output logic [2:0]               status,
  output logic signed [DATA_W-1:0] result_value,
  output logic                     last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  sli_ctl_t         ctl;
  logic [CNT_W-1:0] count;

  sli_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .count  (count),
    .busy   (busy),
    .ctl    (ctl)
  );

  sli_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .operand_value(operand_value),
    .count        (count),
    .result_strobe(result_strobe),
    .status       (status),
    .result_value (result_value),
    .last         (last)
  );

endmodule

/* tb/testbench.sv */
module testbench;
  import sli_pkg::*;

  localparam int CAPACITY = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } list_result_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               command;
  logic signed [DATA_W-1:0] operand_value;
  logic                     result_strobe;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] result_value;
  logic                     last;

  // testbench copy of the store, kept sorted ascending
  logic signed [DATA_W-1:0] sorted_copy[$];
  list_result_t             pending_results[$];

  bit no_gaps;
  int items_sent;
  int results_checked;
  int mismatches;
  int full_rejects;
  int deletions;
  int misses;
  int listings;

  sorted_list_insert_remove_unit #(.CAPACITY(CAPACITY)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .operand_value (operand_value),
    .result_strobe (result_strobe),
    .status        (status),
    .result_value  (result_value),
    .last          (last)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic void queue_result(logic [2:0] st, logic signed [DATA_W-1:0] val,
                                       logic lst);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // update the sorted copy and queue the results this item causes
  function automatic void apply_to_sorted_copy(logic [1:0] cmd,
                                               logic signed [DATA_W-1:0] val);
    int pos;
    case (cmd)
      CMD_INSERT: begin
        if (sorted_copy.size() >= CAPACITY) begin
          queue_result(ST_FULL, val, 1'b1);
          full_rejects++;
        end else begin
          pos = 0;
          while (pos < sorted_copy.size() && sorted_copy[pos] < val) pos++;
          sorted_copy.insert(pos, val);
          queue_result(ST_INSERTED, val, 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (sorted_copy.size() == 0) begin
          queue_result(ST_EMPTY, val, 1'b1);
        end else begin
          pos = 0;
          while (pos < sorted_copy.size() && sorted_copy[pos] != val) pos++;
          if (pos == sorted_copy.size()) begin
            queue_result(ST_NOT_FOUND, val, 1'b1);
            misses++;
          end else begin
            sorted_copy.delete(pos);
            queue_result(ST_DELETED, val, 1'b1);
            deletions++;
          end
        end
      end
      CMD_DISPLAY: begin
        listings++;
        if (sorted_copy.size() == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (sorted_copy[i])
            queue_result(ST_LISTED, sorted_copy[i], i == sorted_copy.size() - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3 && sorted_copy.size() != 0)
      return sorted_copy[$urandom_range(0, sorted_copy.size() - 1)];
    if (r < 7) return $signed($urandom_range(0, 16)) - 8;
    if (r == 7) begin
      case ($urandom_range(0, 3))
        0: return MIN_VAL;
        1: return MAX_VAL;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // hold start until the block takes the item, then predict
  task automatic send_item(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    command       <= cmd;
    operand_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_sorted_copy(cmd, val);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_item(CMD_DISPLAY, MAX_VAL);
    send_item(CMD_REMOVE, MIN_VAL);
    send_item(CMD_UNUSED, MAX_VAL);
    send_item(CMD_REMOVE, 0);
    send_item(CMD_DISPLAY, 0);
  endtask

  task automatic test_extremes_and_duplicates();
    send_item(CMD_INSERT, MAX_VAL);
    send_item(CMD_INSERT, MIN_VAL);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, 0);
    send_item(CMD_INSERT, -1);
    send_item(CMD_INSERT, MIN_VAL);
    send_item(CMD_UNUSED, 5);
    send_item(CMD_DISPLAY, -1);
    send_item(CMD_REMOVE, 0);
    send_item(CMD_REMOVE, 7);
    send_item(CMD_REMOVE, MIN_VAL);
    send_item(CMD_DISPLAY, 0);
    send_item(CMD_REMOVE, MAX_VAL);
    send_item(CMD_REMOVE, 0);
    send_item(CMD_REMOVE, -1);
    send_item(CMD_REMOVE, MIN_VAL);
    send_item(CMD_DISPLAY, MIN_VAL);
  endtask

  // fill to capacity, bounce inserts off the full store, then empty it again
  task automatic test_fill_and_drain();
    while (sorted_copy.size() < CAPACITY) send_item(CMD_INSERT, pick_value());
    send_item(CMD_INSERT, pick_value());
    send_item(CMD_INSERT, MIN_VAL);
    send_item(CMD_DISPLAY, pick_value());
    pause_until_drained();
    while (sorted_copy.size() != 0) begin
      case ($urandom_range(0, 7))
        0: send_item(CMD_REMOVE, $urandom);
        1: send_item(CMD_DISPLAY, $urandom);
        default: send_item(CMD_REMOVE,
                           sorted_copy[$urandom_range(0, sorted_copy.size() - 1)]);
      endcase
    end
    send_item(CMD_DISPLAY, 0);
    send_item(CMD_REMOVE, pick_value());
  endtask

  task automatic test_random_mix(input int count);
    int done;
    int r;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 19);
      if (r < 9) send_item(CMD_INSERT, pick_value());
      else if (r < 16) send_item(CMD_REMOVE, pick_value());
      else if (r < 19) send_item(CMD_DISPLAY, $urandom);
      else send_item(CMD_UNUSED, $urandom);
      if (r < 19) done++;
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result status=%0d value=%0d last=%0b",
                   status, result_value, last);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (status !== want.status || result_value !== want.value || last !== want.last)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch expected status=%0d value=%0d last=%0b, got %0d %0d %0b",
                     want.status, want.value, want.last, status, result_value, last);
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_INSERT;
    operand_value = '0;
    no_gaps       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_store();
    test_extremes_and_duplicates();
    test_fill_and_drain();
    no_gaps = 1'b1;
    test_fill_and_drain();
    no_gaps = 1'b0;
    test_random_mix(60);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);

    $display("tb: %0d items, %0d results checked", items_sent, results_checked);
    $display("tb: %0d full rejections, %0d deletions, %0d misses, %0d displays",
             full_rejects, deletions, misses, listings);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
hdl/sli_pkg.sv
hdl/sli_datapath.sv
hdl/sli_ctrl.sv
hdl/sorted_list_insert_remove_unit.sv
tb/testbench.sv
